### hdl/bfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_pkg
// Types and constants shared by the box filter downscaler modules.
// ----------------------------------------------------------------------------
package bfd_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

   localparam logic [10:0] RST_SRC_WIDTH  = 11'd576;
   localparam logic [10:0] RST_SRC_HEIGHT = 11'd288;
   localparam logic [8:0]  RST_DST_WIDTH  = 9'd144;
   localparam logic [8:0]  RST_DST_HEIGHT = 9'd72;

   localparam int          DST_ROW_LIMIT = 256;
   localparam logic [7:0]  OPAQUE        = 8'hff;
   localparam int          MEAN_STEPS    = 8;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] avg_red;
      logic [7:0] avg_green;
      logic [7:0] avg_blue;
      logic [7:0] alpha;
      logic       last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic ediv_load;
      logic take;
      logic acc;
      logic mdiv_step;
      logic put;
   } cmd_type;

   typedef struct packed {
      logic ediv_busy;
      logic emit;
      logic mdiv_last;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

### hdl/bfd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_ctrl
// Sequencer: edge division after reset or register write, then per pixel
// read / accumulate, and the mean division for pixels that close a block.
// ----------------------------------------------------------------------------
module bfd_ctrl
   import bfd_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      csr_we,
   input  wire      req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_PREP_LOAD,
      S_PREP_RUN,
      S_IDLE,
      S_ACC,
      S_DIV,
      S_PUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   assign req_ready = req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_PREP_LOAD: begin
            cmd.ediv_load = 1'b1;
            state_in      = S_PREP_RUN;
         end
         S_PREP_RUN: begin
            if (!stat.ediv_busy) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.take = 1'b1;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.emit ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            cmd.mdiv_step = 1'b1;
            if (stat.mdiv_last) state_in = S_PUT;
         end
         S_PUT: begin
            // wait for room in the output register
            if (stat.out_free) begin
               cmd.put  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_PREP_LOAD;
      endcase
      if (csr_we) state_in = S_PREP_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PREP_LOAD;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
      end
   end

endmodule
`default_nettype wire

### hdl/bfd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_datapath
// Size registers, block edge tracking, column accumulator memory, the
// edge and mean dividers and the output register.
// ----------------------------------------------------------------------------
module bfd_datapath
   import bfd_pkg::*;
#(
   parameter int MAX_SRC_W = 1024,
   parameter int MAX_SRC_H = 1024,
   parameter int MAX_DST_W = 256
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_we,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata,
   input  req_type                req_data,
   input  cmd_type                cmd,
   output stat_type               stat,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output rsp_type                rsp_data
);

   localparam int XW    = $clog2(MAX_SRC_W + 1);
   localparam int YW    = $clog2(MAX_SRC_H + 1);
   localparam int W     = (XW > YW) ? XW : YW;
   localparam int EC    = $clog2(W);
   localparam int CW    = $clog2(MAX_DST_W);
   localparam int CNT_W = $clog2(MAX_SRC_W * MAX_SRC_H + 1);
   localparam int SUM_W = $clog2(64'(255) * MAX_SRC_W * MAX_SRC_H + 1);
   localparam int MW    = CNT_W + MEAN_STEPS;

   typedef struct packed {
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] b;
      logic [CNT_W-1:0] n;
   } ent_type;

   // size registers
   logic [10:0] src_w_ff, src_h_ff;
   logic [8:0]  dst_w_ff, dst_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= RST_SRC_WIDTH;
         src_h_ff <= RST_SRC_HEIGHT;
         dst_w_ff <= RST_DST_WIDTH;
         dst_h_ff <= RST_DST_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            REG_SRC_WIDTH:  src_w_ff <= csr_wdata[10:0];
            REG_SRC_HEIGHT: src_h_ff <= csr_wdata[10:0];
            REG_DST_WIDTH:  dst_w_ff <= csr_wdata[8:0];
            REG_DST_HEIGHT: dst_h_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // effective sizes; destination never exceeds source
   logic [W-1:0] sw, sh, dw, dh;

   always_comb begin
      sw = (src_w_ff == '0) ? W'(1) :
           (32'(src_w_ff) > MAX_SRC_W) ? W'(MAX_SRC_W) : W'(src_w_ff);
      sh = (src_h_ff == '0) ? W'(1) :
           (32'(src_h_ff) > MAX_SRC_H) ? W'(MAX_SRC_H) : W'(src_h_ff);
      if (dst_w_ff == '0)
         dw = W'(1);
      else if (32'(dst_w_ff) > MAX_DST_W || 32'(dst_w_ff) > 32'(sw))
         dw = (MAX_DST_W < 32'(sw)) ? W'(MAX_DST_W) : sw;
      else
         dw = W'(dst_w_ff);
      if (dst_h_ff == '0)
         dh = W'(1);
      else if (32'(dst_h_ff) > DST_ROW_LIMIT || 32'(dst_h_ff) > 32'(sh))
         dh = (DST_ROW_LIMIT < 32'(sh)) ? W'(DST_ROW_LIMIT) : sh;
      else
         dh = W'(dst_h_ff);
   end

   // edge divider: src/dst quotient and remainder on both axes, one bit a cycle
   logic [W-1:0]  num_c_ff, num_r_ff, qc_ff, qr_ff, rc_ff, rr_ff;
   logic [EC-1:0] ecnt_ff;
   logic          ebusy_ff, edone_ff;
   logic [W:0]    tc, tr;

   assign tc = {rc_ff, num_c_ff[W-1]};
   assign tr = {rr_ff, num_r_ff[W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         ebusy_ff <= 1'b0;
         edone_ff <= 1'b0;
      end else begin
         edone_ff <= ebusy_ff && (ecnt_ff == '0);
         if (cmd.ediv_load)
            ebusy_ff <= 1'b1;
         else if (ecnt_ff == '0)
            ebusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ediv_load) begin
         num_c_ff <= sw;
         num_r_ff <= sh;
         rc_ff    <= '0;
         rr_ff    <= '0;
         qc_ff    <= '0;
         qr_ff    <= '0;
         ecnt_ff  <= EC'(W - 1);
      end else if (ebusy_ff) begin
         num_c_ff <= num_c_ff << 1;
         num_r_ff <= num_r_ff << 1;
         ecnt_ff  <= ecnt_ff - 1'b1;
         if (tc >= {1'b0, dw}) begin
            rc_ff <= W'(tc - {1'b0, dw});
            qc_ff <= {qc_ff[W-2:0], 1'b1};
         end else begin
            rc_ff <= W'(tc);
            qc_ff <= {qc_ff[W-2:0], 1'b0};
         end
         if (tr >= {1'b0, dh}) begin
            rr_ff <= W'(tr - {1'b0, dh});
            qr_ff <= {qr_ff[W-2:0], 1'b1};
         end else begin
            rr_ff <= W'(tr);
            qr_ff <= {qr_ff[W-2:0], 1'b0};
         end
      end
   end

   // position and block edges
   logic [W-1:0]  sx_ff, sy_ff, cstart_ff, rstart_ff, cedge_ff, redge_ff;
   logic [W-1:0]  crem_ff, rrem_ff;
   logic [CW-1:0] col_ff;
   logic [W:0]    sx1, sy1, csum, rsum;
   logic          ccarry, rcarry, col_hit, first, emit, last, restart;
   logic [W-1:0]  cedge_nx, redge_nx, crem_nx, rrem_nx;

   always_comb begin
      sx1      = {1'b0, sx_ff} + 1'b1;
      sy1      = {1'b0, sy_ff} + 1'b1;
      col_hit  = (sx1 == {1'b0, cedge_ff});
      first    = (sy_ff == rstart_ff) && (sx_ff == cstart_ff);
      emit     = col_hit && (sy1 == {1'b0, redge_ff});
      last     = (sx1 >= {1'b0, sw}) && (sy1 >= {1'b0, sh});
      // next edge = edge + q + carry of the remainder
      csum     = {1'b0, crem_ff} + {1'b0, rc_ff};
      ccarry   = (csum >= {1'b0, dw});
      crem_nx  = ccarry ? W'(csum - {1'b0, dw}) : W'(csum);
      cedge_nx = W'({1'b0, cedge_ff} + {1'b0, qc_ff} + (W+1)'(ccarry));
      rsum     = {1'b0, rrem_ff} + {1'b0, rr_ff};
      rcarry   = (rsum >= {1'b0, dh});
      rrem_nx  = rcarry ? W'(rsum - {1'b0, dh}) : W'(rsum);
      redge_nx = W'({1'b0, redge_ff} + {1'b0, qr_ff} + (W+1)'(rcarry));
      restart  = edone_ff || (cmd.acc && last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff     <= '0;
         sy_ff     <= '0;
         col_ff    <= '0;
         cstart_ff <= '0;
         rstart_ff <= '0;
         cedge_ff  <= '0;
         redge_ff  <= '0;
         crem_ff   <= '0;
         rrem_ff   <= '0;
      end else if (restart) begin
         sx_ff     <= '0;
         sy_ff     <= '0;
         col_ff    <= '0;
         cstart_ff <= '0;
         rstart_ff <= '0;
         cedge_ff  <= qc_ff;
         redge_ff  <= qr_ff;
         crem_ff   <= rc_ff;
         rrem_ff   <= rr_ff;
      end else if (cmd.acc) begin
         if (sx1 >= {1'b0, sw}) begin
            sx_ff     <= '0;
            col_ff    <= '0;
            cstart_ff <= '0;
            cedge_ff  <= qc_ff;
            crem_ff   <= rc_ff;
            sy_ff     <= W'(sy1);
            if (sy1 >= {1'b0, redge_ff}) begin
               rstart_ff <= redge_ff;
               redge_ff  <= redge_nx;
               rrem_ff   <= rrem_nx;
            end
         end else begin
            sx_ff <= W'(sx1);
            if (col_hit) begin
               col_ff    <= col_ff + 1'b1;
               cstart_ff <= cedge_ff;
               cedge_ff  <= cedge_nx;
               crem_ff   <= crem_nx;
            end
         end
      end
   end

   // column accumulators: read on take, read-modify-write on acc
   ent_type mem [MAX_DST_W];
   ent_type rd_ff, wr;
   req_type pix_ff;

   always_comb begin
      if (first) begin
         wr.r = SUM_W'(pix_ff.red);
         wr.g = SUM_W'(pix_ff.green);
         wr.b = SUM_W'(pix_ff.blue);
         wr.n = CNT_W'(1);
      end else begin
         wr.r = rd_ff.r + SUM_W'(pix_ff.red);
         wr.g = rd_ff.g + SUM_W'(pix_ff.green);
         wr.b = rd_ff.b + SUM_W'(pix_ff.blue);
         wr.n = rd_ff.n + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pix_ff <= req_data;
         rd_ff  <= mem[col_ff];
      end
      if (cmd.acc) mem[col_ff] <= wr;
   end

   // mean divider: quotient is below 256, so eight restoring steps
   logic [MW-1:0] mrem_ff [3];
   logic [MW-1:0] dsr_ff;
   logic [7:0]    mq_ff [3];
   logic [2:0]    mcnt_ff;
   logic          mlast_ff;

   always_ff @(posedge clock) begin
      if (cmd.acc && emit) begin
         mrem_ff[0] <= MW'(wr.r);
         mrem_ff[1] <= MW'(wr.g);
         mrem_ff[2] <= MW'(wr.b);
         dsr_ff     <= MW'({wr.n, 7'b0});
         mcnt_ff    <= 3'(MEAN_STEPS - 1);
         mlast_ff   <= last;
      end else if (cmd.mdiv_step) begin
         dsr_ff  <= dsr_ff >> 1;
         mcnt_ff <= mcnt_ff - 1'b1;
         for (int i = 0; i < 3; i++) begin
            if (mrem_ff[i] >= dsr_ff) begin
               mrem_ff[i] <= mrem_ff[i] - dsr_ff;
               mq_ff[i]   <= {mq_ff[i][6:0], 1'b1};
            end else begin
               mq_ff[i]   <= {mq_ff[i][6:0], 1'b0};
            end
         end
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.put) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         rsp_data_ff.avg_red       <= mq_ff[0];
         rsp_data_ff.avg_green     <= mq_ff[1];
         rsp_data_ff.avg_blue      <= mq_ff[2];
         rsp_data_ff.alpha         <= OPAQUE;
         rsp_data_ff.last_of_frame <= mlast_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stat.ediv_busy = ebusy_ff || edone_ff;
   assign stat.emit      = emit;
   assign stat.mdiv_last = (mcnt_ff == '0);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

### hdl/box_filter_image_downscaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_image_downscaler
// Shrinks a raster RGB frame by averaging rectangular source blocks.
//
//   channel  dir  handshake             word
//   req_     in   req_valid/req_ready   req_type: one source pixel
//   rsp_     out  rsp_valid/rsp_ready   rsp_type: block mean, alpha, last
//   csr_     in   csr_we                csr_index, csr_wdata
//
// A pixel is read from the column memory, then accumulated and written back;
// a pixel that closes a block also runs the 8-step mean division.
// The output register lets the next pixel in while a word waits on rsp_.
// After reset or any register write, req_ready stays low while the edge
// division runs.
// ----------------------------------------------------------------------------
module box_filter_image_downscaler
   import bfd_pkg::*;
#(
   parameter int MAX_SRC_W = 1024,
   parameter int MAX_SRC_H = 1024,
   parameter int MAX_DST_W = 256
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output rsp_type              rsp_data,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   bfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfd_datapath #(
      .MAX_SRC_W (MAX_SRC_W),
      .MAX_SRC_H (MAX_SRC_H),
      .MAX_DST_W (MAX_DST_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
